@@ design/tbdl_pkg.sv @@
`default_nettype none

package tbdl_pkg;

  // Button geometry and point limits.
  localparam int NUM_BUTTONS    = 3;
  localparam int CARRIED_POINTS = 2;

  // Depth of the queue between the classifier and the state update.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Left edges of the left, middle and right buttons.
  localparam logic [NUM_BUTTONS-1:0][15:0] LEFT_EDGE = {16'd224, 16'd117, 16'd10};

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_HOLD_LEFT   = 3'd1;
  localparam logic [2:0] REG_HOLD_MIDDLE = 3'd2;
  localparam logic [2:0] REG_HOLD_RIGHT  = 3'd3;
  localparam logic [2:0] REG_TOP         = 3'd4;
  localparam logic [2:0] REG_WIDTH       = 3'd5;
  localparam logic [2:0] REG_HEIGHT      = 3'd6;
  localparam logic [2:0] REG_ENABLE      = 3'd7;

  // Register reset values.
  localparam logic [15:0] RST_DEBOUNCE = 16'd3;
  localparam logic [15:0] RST_TOP      = 16'd241;
  localparam logic [15:0] RST_WIDTH    = 16'd86;
  localparam logic [15:0] RST_HEIGHT   = 16'd38;

  // Bit offsets of the event groups in the enable register.
  localparam int EN_PRESS_LSB   = 0;
  localparam int EN_RELEASE_LSB = 3;
  localparam int EN_HOLD_LSB    = 6;

  typedef struct packed {
    logic [31:0] now_tick;
    logic [1:0]  point_count;
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [15:0] second_x;
    logic [15:0] second_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0] press_mask;
    logic [2:0] hold_mask;
    logic [2:0] release_mask;
    logic [2:0] held_now;
  } out_word_t;

  typedef struct packed {
    logic [15:0]                        debounce_ticks;
    logic [NUM_BUTTONS-1:0][15:0]       hold_ticks;
    logic [15:0]                        region_top;
    logic [15:0]                        region_width;
    logic [15:0]                        region_height;
    logic [8:0]                         event_enable;
  } cfg_t;

  // A classified poll: its time stamp and the raw touch bit of each button.
  typedef struct packed {
    logic [31:0]            now_tick;
    logic [NUM_BUTTONS-1:0] raw;
  } cls_word_t;

endpackage

`default_nettype wire

@@ design/tbdl_front.sv @@
`default_nettype none

module tbdl_front #(
  parameter int TouchPoints = 2
) (
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  tbdl_pkg::in_word_t   in_word_i,
  input  tbdl_pkg::cfg_t       cfg_i,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output tbdl_pkg::cls_word_t  q_word_o
);

  localparam int LimitInt = (TouchPoints < tbdl_pkg::CARRIED_POINTS) ?
                            TouchPoints : tbdl_pkg::CARRIED_POINTS;
  localparam logic [1:0] Limit = 2'(LimitInt);

  logic [1:0]                                   count;
  logic [tbdl_pkg::CARRIED_POINTS-1:0][15:0]    px;
  logic [tbdl_pkg::CARRIED_POINTS-1:0][15:0]    py;
  logic [tbdl_pkg::NUM_BUTTONS-1:0][16:0]       x_end;
  logic [16:0]                                  y_end;
  logic [tbdl_pkg::NUM_BUTTONS-1:0][tbdl_pkg::CARRIED_POINTS-1:0] hit;
  logic [tbdl_pkg::NUM_BUTTONS-1:0]             raw;

  // The front side is never held up except by a full queue.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Clamp the point count to the points that are actually carried.
  assign count = (in_word_i.point_count > Limit) ? Limit : in_word_i.point_count;
  assign px    = {in_word_i.second_x, in_word_i.first_x};
  assign py    = {in_word_i.second_y, in_word_i.first_y};
  assign y_end = {1'b0, cfg_i.region_top} + {1'b0, cfg_i.region_height};

  // Test every valid point against every button region; the far edges
  // are formed one bit wider so a region may run past the coordinate range.
  always_comb begin
    for (int b = 0; b < tbdl_pkg::NUM_BUTTONS; b++) begin
      x_end[b] = {1'b0, tbdl_pkg::LEFT_EDGE[b]} + {1'b0, cfg_i.region_width};
      for (int p = 0; p < tbdl_pkg::CARRIED_POINTS; p++) begin
        hit[b][p] = (count > 2'(p)) &&
                    (px[p] >= tbdl_pkg::LEFT_EDGE[b]) &&
                    ({1'b0, px[p]} < x_end[b]) &&
                    (py[p] >= cfg_i.region_top) &&
                    ({1'b0, py[p]} < y_end);
      end
      raw[b] = |hit[b];
    end
  end

  assign q_word_o.now_tick = in_word_i.now_tick;
  assign q_word_o.raw      = raw;

endmodule

`default_nettype wire

@@ design/tbdl_queue.sv @@
`default_nettype none

module tbdl_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  tbdl_pkg::cls_word_t  push_word_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output tbdl_pkg::cls_word_t  pop_word_o
);

  tbdl_pkg::cls_word_t                 mem_q [tbdl_pkg::QUEUE_DEPTH];
  logic [tbdl_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tbdl_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tbdl_pkg::QUEUE_CNT_W-1:0]    cnt_q, cnt_d;
  logic                                do_push;
  logic                                do_pop;

  assign full_o     = (cnt_q == tbdl_pkg::QUEUE_CNT_W'(tbdl_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_word_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

@@ design/tbdl_back.sv @@
`default_nettype none

module tbdl_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tbdl_pkg::cfg_t       cfg_i,
  input  wire                  q_valid_i,
  input  tbdl_pkg::cls_word_t  q_word_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output tbdl_pkg::out_word_t  out_word_o
);

  localparam int NB = tbdl_pkg::NUM_BUTTONS;

  logic [NB-1:0]        deb_q, deb_d;
  logic [NB-1:0]        raw_prev_q, raw_prev_d;
  logic [NB-1:0]        hold_rep_q, hold_rep_d;
  logic [NB-1:0][31:0]  chg_tick_q, chg_tick_d;
  logic [NB-1:0][31:0]  prs_tick_q, prs_tick_d;
  logic [NB-1:0][31:0]  chg_age;
  logic [NB-1:0][31:0]  prs_age;
  logic [NB-1:0]        settle;
  logic [NB-1:0]        press;
  logic [NB-1:0]        release_ev;
  logic [NB-1:0]        hold;
  logic                 out_valid_q;
  tbdl_pkg::out_word_t  out_word_q, out_word_d;
  logic                 advance;
  logic [31:0]          now;

  // The output register moves whenever it is empty or being taken.
  assign advance     = !out_valid_q || !out_stall_i;
  assign q_pop_o     = q_valid_i && advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign now         = q_word_i.now_tick;

  // Per-button debounce and long-press update for the word at the queue head.
  always_comb begin
    deb_d      = deb_q;
    raw_prev_d = raw_prev_q;
    hold_rep_d = hold_rep_q;
    chg_tick_d = chg_tick_q;
    prs_tick_d = prs_tick_q;
    press      = '0;
    release_ev = '0;
    hold       = '0;
    for (int b = 0; b < NB; b++) begin
      if (q_word_i.raw[b] != raw_prev_q[b]) begin
        raw_prev_d[b] = q_word_i.raw[b];
        chg_tick_d[b] = now;
      end
      chg_age[b] = now - chg_tick_d[b];
      settle[b]  = (cfg_i.debounce_ticks == '0) ||
                   (chg_age[b] >= {16'd0, cfg_i.debounce_ticks});
      if ((q_word_i.raw[b] != deb_q[b]) && settle[b]) begin
        deb_d[b]      = q_word_i.raw[b];
        hold_rep_d[b] = 1'b0;
        if (q_word_i.raw[b]) begin
          prs_tick_d[b] = now;
          press[b]      = 1'b1;
        end else begin
          release_ev[b] = 1'b1;
        end
      end
      prs_age[b] = now - prs_tick_d[b];
      if (deb_d[b] && !hold_rep_d[b] && (cfg_i.hold_ticks[b] != '0) &&
          (prs_age[b] >= {16'd0, cfg_i.hold_ticks[b]})) begin
        hold_rep_d[b] = 1'b1;
        hold[b]       = 1'b1;
      end
    end
  end

  // Gate the events with their enable bits.
  always_comb begin
    out_word_d.press_mask   = press &
        cfg_i.event_enable[tbdl_pkg::EN_PRESS_LSB +: NB];
    out_word_d.hold_mask    = hold &
        cfg_i.event_enable[tbdl_pkg::EN_HOLD_LSB +: NB];
    out_word_d.release_mask = release_ev &
        cfg_i.event_enable[tbdl_pkg::EN_RELEASE_LSB +: NB];
    out_word_d.held_now     = deb_d;
  end

  // Button state commits only when a word is taken from the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q       <= '0;
      raw_prev_q  <= '0;
      hold_rep_q  <= '0;
      chg_tick_q  <= '0;
      prs_tick_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        deb_q      <= deb_d;
        raw_prev_q <= raw_prev_d;
        hold_rep_q <= hold_rep_d;
        chg_tick_q <= chg_tick_d;
        prs_tick_q <= prs_tick_d;
      end
      if (advance) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

`default_nettype wire

@@ design/touch_button_debounce_longpress.sv @@
// Channel  | Valid        | Stall        | Word
// ---------+--------------+--------------+-------------------------------
// input    | in_valid_i   | in_stall_o   | in_word_i  (one touch poll)
// output   | out_valid_o  | out_stall_i  | out_word_o (event masks)
// config   | psel/penable | pready (=1)  | paddr/pwdata/prdata, 4-byte regs
//
// One poll per cycle sustained while out_stall_i is low; a poll's result is
// classified into the queue, then passes one state update into the output
// register. The two-entry queue between classifier and state update
// absorbs output stalls; in_stall_o rises only when it is full.
// Reset clears the button state and loads the register defaults; no
// clearing pass is needed.
`default_nettype none

module touch_button_debounce_longpress #(
  parameter int TouchPoints = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  tbdl_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output tbdl_pkg::out_word_t  out_word_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tbdl_pkg::cfg_t       cfg_q;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  tbdl_pkg::cls_word_t  push_word;
  tbdl_pkg::cls_word_t  head_word;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= tbdl_pkg::RST_DEBOUNCE;
      cfg_q.hold_ticks     <= '0;
      cfg_q.region_top     <= tbdl_pkg::RST_TOP;
      cfg_q.region_width   <= tbdl_pkg::RST_WIDTH;
      cfg_q.region_height  <= tbdl_pkg::RST_HEIGHT;
      cfg_q.event_enable   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        tbdl_pkg::REG_DEBOUNCE:    cfg_q.debounce_ticks <= pwdata[15:0];
        tbdl_pkg::REG_HOLD_LEFT:   cfg_q.hold_ticks[0]  <= pwdata[15:0];
        tbdl_pkg::REG_HOLD_MIDDLE: cfg_q.hold_ticks[1]  <= pwdata[15:0];
        tbdl_pkg::REG_HOLD_RIGHT:  cfg_q.hold_ticks[2]  <= pwdata[15:0];
        tbdl_pkg::REG_TOP:         cfg_q.region_top     <= pwdata[15:0];
        tbdl_pkg::REG_WIDTH:       cfg_q.region_width   <= pwdata[15:0];
        tbdl_pkg::REG_HEIGHT:      cfg_q.region_height  <= pwdata[15:0];
        tbdl_pkg::REG_ENABLE:      cfg_q.event_enable   <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      tbdl_pkg::REG_DEBOUNCE:    prdata = {16'd0, cfg_q.debounce_ticks};
      tbdl_pkg::REG_HOLD_LEFT:   prdata = {16'd0, cfg_q.hold_ticks[0]};
      tbdl_pkg::REG_HOLD_MIDDLE: prdata = {16'd0, cfg_q.hold_ticks[1]};
      tbdl_pkg::REG_HOLD_RIGHT:  prdata = {16'd0, cfg_q.hold_ticks[2]};
      tbdl_pkg::REG_TOP:         prdata = {16'd0, cfg_q.region_top};
      tbdl_pkg::REG_WIDTH:       prdata = {16'd0, cfg_q.region_width};
      tbdl_pkg::REG_HEIGHT:      prdata = {16'd0, cfg_q.region_height};
      tbdl_pkg::REG_ENABLE:      prdata = {23'd0, cfg_q.event_enable};
      default:                   prdata = '0;
    endcase
  end

  // Classifier: finds which buttons each poll touches.
  tbdl_front #(
    .TouchPoints(TouchPoints)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  // Queue between classifier and state update.
  tbdl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (head_word)
  );

  // Debounce, long-press and event generation.
  tbdl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_word_i    (head_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

@@ design/tbdl_checker.sv @@
`default_nettype none

module tbdl_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_stall_o,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input tbdl_pkg::out_word_t  out_word_o
);

  logic       out_take;
  logic [2:0] last_held_q;

  assign out_take = out_valid_o && !out_stall_i;

  // Held state as shown by the last delivered word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_held_q <= '0;
    end else if (out_take) begin
      last_held_q <= out_word_o.held_now;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // A press needs the button released in the previous word, a release pressed.
  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take |-> (((out_word_o.press_mask & last_held_q) == 3'd0) &&
                  ((out_word_o.release_mask & ~last_held_q) == 3'd0)))
    else $error("press or release does not match previous held state");

  // The input side stalls only after the output side held up the queue.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without an output stall");

  // Press and long press come only with the button held, release only without.
  a_mask_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((((out_word_o.press_mask | out_word_o.hold_mask) &
                       ~out_word_o.held_now) == 3'd0) &&
                     ((out_word_o.release_mask & out_word_o.held_now) == 3'd0)))
    else $error("event mask disagrees with held state");

endmodule

bind touch_button_debounce_longpress tbdl_checker u_tbdl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
